[hw/rtl/trba_pkg.sv]
package trba_pkg;

   localparam int NUM_BLOCKS_DEF = 1024;
   localparam int BLOCK_BYTES    = 4096;
   localparam int BLK_SH         = $clog2(BLOCK_BYTES);

   // total_blocks register width and the widest map address any build needs
   localparam int TOT_W   = 11;
   localparam int MAP_AW  = 16;
   localparam logic [TOT_W-1:0] TOT_RESET = 11'd1024;

   // floor(x/3) == (x * DIV3_MUL) >> DIV3_SH for every x below 2^TOT_W
   localparam logic [11:0] DIV3_MUL = 12'd2731;
   localparam int          DIV3_SH  = 13;

   localparam logic [1:0] MAP_FREE = 2'd0;
   localparam logic [1:0] MAP_USED = 2'd1;
   localparam logic [1:0] MAP_END  = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_WRONG   = 3'd2;
   localparam logic [2:0] ST_OUTSIDE = 3'd3;
   localparam logic [2:0] ST_FREED   = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic CSR_TOTAL = 1'b0;
   localparam logic CSR_BASE  = 1'b1;

   typedef struct packed {
      logic              wr_en;
      logic [MAP_AW-1:0] wr_addr;
      logic [1:0]        wr_data;
      logic              rd_en;
      logic [MAP_AW-1:0] rd_addr;
   } map_req_type;

endpackage

[hw/rtl/trba_map_mem.sv]
module trba_map_mem #(
   parameter int NUM_BLOCKS = trba_pkg::NUM_BLOCKS_DEF
) (
   input  logic                  clock,
   input  trba_pkg::map_req_type map_req,
   output logic [1:0]            map_rd_data
);
   import trba_pkg::*;

   localparam int IW = $clog2(NUM_BLOCKS);

   logic [1:0] mem [NUM_BLOCKS];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem[IW'(map_req.wr_addr)] <= map_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (map_req.rd_en) begin
         rd_data_ff <= mem[IW'(map_req.rd_addr)];
      end
   end

   assign map_rd_data = rd_data_ff;

endmodule

[hw/rtl/trba_ctrl.sv]
module trba_ctrl #(
   parameter int NUM_BLOCKS = trba_pkg::NUM_BLOCKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic                        req_heap_select,
   input  logic [31:0]                 req_byte_size,
   input  logic [31:0]                 req_free_address,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic [31:0]                 rsp_alloc_address,
   input  logic [trba_pkg::TOT_W-1:0]  total_blocks,
   input  logic [31:0]                 base_address,
   output trba_pkg::map_req_type       map_req,
   input  logic [1:0]                  map_rd_data
);
   import trba_pkg::*;

   localparam int IW = $clog2(NUM_BLOCKS);
   localparam int NW = 33 - BLK_SH;
   localparam int PW = TOT_W + 12;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b000_0000_0001,
      S_IDLE  = 11'b000_0000_0010,
      S_DIV   = 11'b000_0000_0100,
      S_BND   = 11'b000_0000_1000,
      S_SCAN  = 11'b000_0001_0000,
      S_MARK  = 11'b000_0010_0000,
      S_FEND  = 11'b000_0100_0000,
      S_FCHK  = 11'b000_1000_0000,
      S_FRD   = 11'b001_0000_0000,
      S_FWALK = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic              op_ff, op_in;
   logic              sel_ff, sel_in;
   logic [31:0]       size_ff, size_in;
   logic [31:0]       addr_ff, addr_in;
   logic [TOT_W-1:0]  q_ff, q_in;
   logic [TOT_W-1:0]  k_ff, k_in;
   logic [TOT_W-1:0]  lo_ff, lo_in;
   logic [TOT_W-1:0]  hi_ff, hi_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [TOT_W:0]    rd_i_ff, rd_i_in;
   logic [TOT_W-1:0]  ev_i_ff, ev_i_in;
   logic [TOT_W-1:0]  run_ff, run_in;
   logic              pend_ff, pend_in;
   logic [TOT_W-1:0]  start_ff, start_in;
   logic [TOT_W-1:0]  last_ff, last_in;
   logic [TOT_W-1:0]  mark_ff, mark_in;
   logic [32:0]       e0_ff, e0_in;
   logic [32:0]       e1_ff, e1_in;
   logic [TOT_W-1:0]  idx_ff, idx_in;
   logic              first_ff, first_in;
   logic [IW-1:0]     clr_ff, clr_in;
   logic [2:0]        res_st_ff, res_st_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;

   logic [TOT_W-1:0]  eff;
   logic [PW-1:0]     prod;
   logic [TOT_W-1:0]  kbound;
   logic [TOT_W:0]    run_nx;
   logic [TOT_W:0]    idx_nx;
   logic [32:0]       a33;
   logic [32:0]       b33;
   logic [32:0]       off;
   logic              in_k;
   logic              in_u;

   always_comb begin
      eff    = (32'(total_blocks) > NUM_BLOCKS) ? TOT_W'(NUM_BLOCKS) : total_blocks;
      prod   = PW'(eff) * PW'(DIV3_MUL);
      kbound = eff - {q_ff[TOT_W-2:0], 1'b0};
      run_nx = {1'b0, run_ff} + 1'b1;
      idx_nx = {1'b0, idx_ff} + 1'b1;
      a33    = {1'b0, addr_ff};
      b33    = {1'b0, base_address};
      off    = a33 - b33;
      in_k   = (a33 >= b33) && (a33 < e0_ff);
      in_u   = (a33 >= e0_ff) && (a33 < e1_ff);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sel_in       = sel_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      n_in         = n_ff;
      rd_i_in      = rd_i_ff;
      ev_i_in      = ev_i_ff;
      run_in       = run_ff;
      pend_in      = pend_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      mark_in      = mark_ff;
      e0_in        = e0_ff;
      e1_in        = e1_ff;
      idx_in       = idx_ff;
      first_in     = first_ff;
      clr_in       = clr_ff;
      res_st_in    = res_st_ff;
      res_addr_in  = res_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in  = rsp_addr_ff;
      map_req      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = MAP_AW'(clr_ff);
            map_req.wr_data = MAP_FREE;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IW'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               sel_in   = req_heap_select;
               size_in  = req_byte_size;
               addr_in  = req_free_address;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            q_in     = TOT_W'(prod >> DIV3_SH);
            state_in = S_BND;
         end
         S_BND: begin
            k_in  = kbound;
            lo_in = sel_ff ? kbound : '0;
            hi_in = sel_ff ? eff : kbound;
            n_in  = (size_ff == 32'd0) ? NW'(1)
                                       : NW'((size_ff - 32'd1) >> BLK_SH) + NW'(1);
            rd_i_in = {1'b0, (sel_ff ? kbound : TOT_W'(0))};
            run_in  = '0;
            pend_in = 1'b0;
            state_in = (op_ff == OP_FREE) ? S_FEND : S_SCAN;
         end
         S_SCAN: begin
            if (pend_ff) begin
               run_in = (map_rd_data == MAP_FREE) ? run_nx[TOT_W-1:0] : '0;
            end
            if (pend_ff && map_rd_data == MAP_FREE && NW'(run_nx) == n_ff) begin
               // run complete: ev_i is its last block
               last_in  = ev_i_ff;
               start_in = ev_i_ff + 1'b1 - n_ff[TOT_W-1:0];
               mark_in  = ev_i_ff + 1'b1 - n_ff[TOT_W-1:0];
               pend_in  = 1'b0;
               state_in = S_MARK;
            end else if (rd_i_ff < {1'b0, hi_ff}) begin
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = MAP_AW'(rd_i_ff);
               ev_i_in = rd_i_ff[TOT_W-1:0];
               rd_i_in = rd_i_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  res_st_in   = ST_FULL;
                  res_addr_in = '0;
                  state_in    = S_DONE;
               end
            end
         end
         S_MARK: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = MAP_AW'(mark_ff);
            map_req.wr_data = (mark_ff == last_ff) ? MAP_END : MAP_USED;
            mark_in = mark_ff + 1'b1;
            if (mark_ff == last_ff) begin
               res_st_in   = ST_OK;
               res_addr_in = base_address + (32'(start_ff) << BLK_SH);
               state_in    = S_DONE;
            end
         end
         S_FEND: begin
            e0_in    = b33 + (33'(k_ff) << BLK_SH);
            e1_in    = b33 + (33'(eff) << BLK_SH);
            state_in = S_FCHK;
         end
         S_FCHK: begin
            res_addr_in = '0;
            idx_in      = TOT_W'(off >> BLK_SH);
            if (sel_ff ? in_k : in_u) begin
               res_st_in = ST_WRONG;
               state_in  = S_DONE;
            end else if (!(sel_ff ? in_u : in_k)) begin
               res_st_in = ST_OUTSIDE;
               state_in  = S_DONE;
            end else begin
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = MAP_AW'(idx_ff);
            first_in = 1'b1;
            state_in = S_FWALK;
         end
         S_FWALK: begin
            first_in = 1'b0;
            if (first_ff && map_rd_data == MAP_FREE) begin
               res_st_in = ST_FREED;
               state_in  = S_DONE;
            end else begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = MAP_AW'(idx_ff);
               map_req.wr_data = MAP_FREE;
               if (map_rd_data == MAP_END || idx_nx >= {1'b0, hi_ff}) begin
                  res_st_in = ST_OK;
                  state_in  = S_DONE;
               end else begin
                  // read the next entry while this one is cleared
                  map_req.rd_en   = 1'b1;
                  map_req.rd_addr = MAP_AW'(idx_nx);
                  idx_in = idx_nx[TOT_W-1:0];
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_st_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sel_ff        <= sel_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      q_ff          <= q_in;
      k_ff          <= k_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      n_ff          <= n_in;
      rd_i_ff       <= rd_i_in;
      ev_i_ff       <= ev_i_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      last_ff       <= last_in;
      mark_ff       <= mark_in;
      e0_ff         <= e0_in;
      e1_ff         <= e1_in;
      idx_ff        <= idx_in;
      first_ff      <= first_in;
      res_st_ff     <= res_st_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_alloc_address = rsp_addr_ff;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> rd_i_ff <= {1'b0, hi_ff})
      else $error("scan pointer past region end");

   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARK |-> (mark_ff >= start_ff) && (mark_ff <= last_ff))
      else $error("mark pointer outside run");

   a_mark_region: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARK |-> (start_ff >= lo_ff) && (last_ff < hi_ff))
      else $error("run outside region");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside done");

endmodule

[hw/rtl/two_region_block_allocator.sv]
// Timing: allocate time grows with the map entries scanned and the run length;
//   free time grows with the entries cleared; the map memory port handles
//   one entry per cycle.
// Throughput: one transaction at a time; the next request is taken while the
//   previous response still waits in the output register.
// Reset: control clears at once, then a pass frees all NUM_BLOCKS map entries,
//   one per cycle, before the first request is taken.
module two_region_block_allocator #(
   parameter int NUM_BLOCKS = trba_pkg::NUM_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic        req_heap_select,
   input  logic [31:0] req_byte_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_alloc_address,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);
   import trba_pkg::*;

   logic [TOT_W-1:0] total_ff, total_in;
   logic [31:0]      base_ff, base_in;
   map_req_type      map_req;
   logic [1:0]       map_rd_data;

   always_comb begin
      total_in = total_ff;
      base_in  = base_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TOTAL: total_in = csr_write_data[TOT_W-1:0];
            CSR_BASE:  base_in  = csr_write_data;
            default:   total_in = total_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOT_RESET;
         base_ff  <= '0;
      end else begin
         total_ff <= total_in;
         base_ff  <= base_in;
      end
   end

   trba_ctrl #(.NUM_BLOCKS(NUM_BLOCKS)) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_heap_select   (req_heap_select),
      .req_byte_size     (req_byte_size),
      .req_free_address  (req_free_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_alloc_address (rsp_alloc_address),
      .total_blocks      (total_ff),
      .base_address      (base_ff),
      .map_req           (map_req),
      .map_rd_data       (map_rd_data)
   );

   trba_map_mem #(.NUM_BLOCKS(NUM_BLOCKS)) u_map (
      .clock       (clock),
      .map_req     (map_req),
      .map_rd_data (map_rd_data)
   );

endmodule

[tb/tb_two_region_block_allocator.sv]
`timescale 1ns / 100ps

module tb_two_region_block_allocator;
   import trba_pkg::*;

   typedef struct {
      logic        op;
      logic        heap;
      logic [31:0] size;
      logic [31:0] addr;
      bit          pick_live;
   } alloc_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] addr;
   } alloc_rsp_type;

   localparam int WATCHDOG_LIMIT = 50000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic        req_heap_select;
   logic [31:0] req_byte_size;
   logic [31:0] req_free_address;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_alloc_address;
   logic        csr_write_enable;
   logic        csr_index;
   logic [31:0] csr_write_data;

   two_region_block_allocator dut (.*);

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   logic [31:0]   live_addrs[2][$];
   logic [1:0]    shadow_map[NUM_BLOCKS_DEF];
   logic [10:0]   shadow_total;
   logic [31:0]   shadow_base;
   int            accepted_reqs;
   int            errors;
   int            quiet_cycles;
   int            idle_mode;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void region_bounds(input logic heap, output int unsigned lo,
                                         output int unsigned hi);
      int unsigned t;
      int unsigned k;
      t = (shadow_total > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : shadow_total;
      k = t / 3 + t % 3;
      if (heap == 1'b0) begin
         lo = 0;
         hi = k;
      end else begin
         lo = k;
         hi = k + (t / 3) * 2;
      end
   endfunction

   function automatic bit addr_in_region(input longint unsigned a, input int unsigned lo,
                                         input int unsigned hi);
      longint unsigned s;
      longint unsigned e;
      s = longint'(shadow_base) + longint'(lo) * BLOCK_BYTES;
      e = longint'(shadow_base) + longint'(hi) * BLOCK_BYTES;
      return a >= s && a < e;
   endfunction

   function automatic alloc_rsp_type first_fit_alloc(input logic heap,
                                                     input logic [31:0] size);
      alloc_rsp_type   r;
      int unsigned     lo, hi, i, run, start, n;
      bit              found;
      longint unsigned sz;
      longint unsigned full_addr;
      sz = (size == 0) ? 1 : size;
      n = int'(sz / BLOCK_BYTES + ((sz % BLOCK_BYTES) != 0));
      region_bounds(heap, lo, hi);
      run = 0;
      start = 0;
      found = 0;
      for (i = lo; i < hi && !found; i++) begin
         if (shadow_map[i] == MAP_FREE) begin
            run++;
            if (run == n) begin
               start = i + 1 - n;
               found = 1;
            end
         end else begin
            run = 0;
         end
      end
      r.addr = '0;
      if (!found) begin
         r.status = ST_FULL;
         return r;
      end
      for (i = start; i < start + n; i++)
         shadow_map[i] = (i == start + n - 1) ? MAP_END : MAP_USED;
      full_addr = longint'(shadow_base) + longint'(start) * BLOCK_BYTES;
      r.status = ST_OK;
      r.addr = full_addr[31:0];
      return r;
   endfunction

   function automatic alloc_rsp_type run_free(input logic heap, input logic [31:0] addr);
      alloc_rsp_type   r;
      int unsigned     lo, hi, olo, ohi, idx;
      longint unsigned a;
      logic [1:0]      v;
      a = addr;
      r.addr = '0;
      region_bounds(heap, lo, hi);
      region_bounds(~heap, olo, ohi);
      if (addr_in_region(a, olo, ohi)) begin
         r.status = ST_WRONG;
         return r;
      end
      if (!addr_in_region(a, lo, hi)) begin
         r.status = ST_OUTSIDE;
         return r;
      end
      idx = int'((a - longint'(shadow_base)) / BLOCK_BYTES);
      if (idx >= hi || idx >= NUM_BLOCKS_DEF) begin
         r.status = ST_OUTSIDE;
         return r;
      end
      if (shadow_map[idx] == MAP_FREE) begin
         r.status = ST_FREED;
         return r;
      end
      for (; idx < hi; idx++) begin
         v = shadow_map[idx];
         shadow_map[idx] = MAP_FREE;
         if (v == MAP_END) break;
      end
      r.status = ST_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) idle_mode <= 0;
      else idle_mode <= (accepted_reqs < 233) ? 0 : (accepted_reqs < 466) ? 1 : 2;
   end

   // driver: predict on acceptance, then present the next transaction
   always @(posedge clock) begin
      alloc_req_type cur;
      alloc_rsp_type exp_rsp;
      int            pick;
      int            hold_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_op == OP_ALLOC) begin
               exp_rsp = first_fit_alloc(req_heap_select, req_byte_size);
               if (exp_rsp.status == ST_OK) live_addrs[req_heap_select].push_back(exp_rsp.addr);
            end else begin
               exp_rsp = run_free(req_heap_select, req_free_address);
            end
            expected_rsps.push_back(exp_rsp);
            accepted_reqs++;
         end
         if (!req_valid || req_ready) begin
            hold_pct = (idle_mode == 0) ? 31 : (idle_mode == 1) ? 72 : 0;
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= hold_pct) begin
               cur = pending_reqs.pop_front();
               if (cur.pick_live && live_addrs[cur.heap].size() > 0) begin
                  pick = $urandom_range(0, live_addrs[cur.heap].size() - 1);
                  cur.addr = live_addrs[cur.heap][pick];
                  if ($urandom_range(0, 1)) live_addrs[cur.heap].delete(pick);
                  // land inside the run now and then
                  if ($urandom_range(0, 5) == 0)
                     cur.addr = cur.addr + $urandom_range(0, 2) * BLOCK_BYTES
                                + $urandom_range(0, BLOCK_BYTES - 1);
               end
               req_op <= cur.op;
               req_heap_select <= cur.heap;
               req_byte_size <= cur.size;
               req_free_address <= cur.addr;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      alloc_rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no transaction outstanding");
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_status);
                  errors++;
               end
               if (rsp_alloc_address !== exp_rsp.addr) begin
                  $error("alloc_address: expected %h, actual %h", exp_rsp.addr,
                         rsp_alloc_address);
                  errors++;
               end
            end
         end
         case (idle_mode)
            0: rsp_ready <= $urandom_range(0, 99) >= 72;
            1: rsp_ready <= $urandom_range(0, 99) >= 31;
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic alloc_req_type make_req(input logic op, input logic heap,
                                              input logic [31:0] size,
                                              input logic [31:0] addr);
      alloc_req_type r;
      r.op = op;
      r.heap = heap;
      r.size = size;
      r.addr = addr;
      r.pick_live = 0;
      return r;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_TOTAL) shadow_total = data[10:0];
      else shadow_base = data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_random(input int count);
      alloc_req_type r;
      int            kind;
      repeat (count) begin
         r = make_req($urandom_range(0, 99) < 55 ? OP_ALLOC : OP_FREE,
                      1'($urandom_range(0, 1)), $urandom, $urandom);
         kind = $urandom_range(0, 99);
         if (r.op == OP_ALLOC) begin
            if (kind < 70) r.size = $urandom_range(0, 3 * BLOCK_BYTES);
            else if (kind < 92) r.size = $urandom_range(0, 20 * BLOCK_BYTES);
            else if (kind < 97) r.size = $urandom;
            else r.size = 32'hFFFF_FFFF;
         end else begin
            r.pick_live = kind < 85;
         end
         pending_reqs.push_back(r);
      end
   endtask

   task automatic run_phase(input logic [10:0] total, input logic [31:0] base, input int count);
      write_csr(CSR_TOTAL, {21'd0, total});
      write_csr(CSR_BASE, base);
      live_addrs[0].delete();
      live_addrs[1].delete();
      queue_random(count);
   endtask

   initial begin
      reset = 1'b1;
      req_op = OP_ALLOC;
      req_heap_select = 1'b0;
      req_byte_size = '0;
      req_free_address = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_TOTAL;
      csr_write_data = '0;
      shadow_total = TOT_RESET;
      shadow_base = '0;
      accepted_reqs = 0;
      errors = 0;
      foreach (shadow_map[i]) shadow_map[i] = MAP_FREE;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // default split: kernel 0..341, user 342..1023
      pending_reqs.push_back(make_req(OP_ALLOC, 1'b0, 32'd0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_ALLOC, 1'b0, 32'd4096, 32'd0));
      pending_reqs.push_back(make_req(OP_ALLOC, 1'b0, 32'd4097, 32'd0));
      pending_reqs.push_back(make_req(OP_ALLOC, 1'b0, 32'hFFFF_FFFF, 32'd0));
      pending_reqs.push_back(make_req(OP_ALLOC, 1'b1, 32'd1, 32'd0));
      pending_reqs.push_back(make_req(OP_FREE, 1'b0, 32'hFFFF_FFFF, 32'd0));
      pending_reqs.push_back(make_req(OP_FREE, 1'b0, 32'd0, 32'd0));
      pending_reqs.push_back(make_req(OP_FREE, 1'b0, 32'd0, 342 * 4096));
      pending_reqs.push_back(make_req(OP_FREE, 1'b1, 32'd0, 32'd4096));
      pending_reqs.push_back(make_req(OP_FREE, 1'b1, 32'd0, 342 * 4096 + 17));
      pending_reqs.push_back(make_req(OP_FREE, 1'b0, 32'd0, 32'hFFFF_FFFF));
      // free the tail of a run, then the head whose end mark is gone
      pending_reqs.push_back(make_req(OP_FREE, 1'b0, 32'd0, 3 * 4096 + 5));
      pending_reqs.push_back(make_req(OP_FREE, 1'b0, 32'd0, 2 * 4096));
      pending_reqs.push_back(make_req(OP_ALLOC, 1'b1, 32'd0, 32'd0));
      pending_reqs.push_back(make_req(OP_FREE, 1'b0, 32'd0, 32'd4096));
      queue_random(180);

      run_phase(11'd3, 32'hFFFF_F000, 60);
      run_phase(11'd0, 32'h1234_5678, 20);
      run_phase(11'd2047, 32'hFFC0_0000, 150);
      run_phase(11'd1, $urandom, 20);
      run_phase(11'd2, $urandom, 20);
      run_phase(11'd100, $urandom, 150);
      run_phase(11'd1024, 32'd0, 80);

      wait_drained();
      repeat (2100) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/trba_pkg.sv
hw/rtl/trba_map_mem.sv
hw/rtl/trba_ctrl.sv
hw/rtl/two_region_block_allocator.sv
tb/tb_two_region_block_allocator.sv
